// ----- hdl/lfht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lfht_pkg;

   // command codes carried on the request tuser
   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_LOOKUP   = 2'd1,
      CMD_FREE     = 2'd2,
      CMD_FREE_ALL = 2'd3
   } cmd_type;

   // status codes carried on the response tuser
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_NO_KEY = 2'd2
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SEND = 3'b100
   } state_type;

   // width of an object address
   localparam int ADDR_W = 32;

endpackage : lfht_pkg

`default_nettype wire

// ----- hdl/lowest_free_handle_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  tvalid/tready          tdata / tuser
// req       in         req_tvalid/req_tready  handle_in, object_address / command
// rsp       out        rsp_tvalid/rsp_tready  handle_out, address_out, live_count / status
//
// an item passes through accept (occupancy row and address read), then execute
// (lowest-zero search in the row, write back), then send; the next item is accepted in the
// cycle the result moves to the output register, so no new item is taken while one is
// in execute, as the occupancy memory does a read-modify-write of one row per item
// reset clears the row valid and row full flags and the live count at once
// a stalled response holds the next item in the send state until rsp_tready

module lowest_free_handle_table_top
   import lfht_pkg::*;
#(
   parameter int HANDLES = 256
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire                                           req_tvalid,
   output logic                                          req_tready,
   // handle_in, object_address, zero fill
   input  wire  [((($clog2(HANDLES + 1) + ADDR_W) + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  wire  [1:0]                                    req_tuser,
   output logic                                          rsp_tvalid,
   input  wire                                           rsp_tready,
   // handle_out, address_out, live_count, zero fill
   output logic [(((2 * $clog2(HANDLES + 1) + ADDR_W) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [1:0]                                    rsp_tuser
);

   localparam int HW    = $clog2(HANDLES + 1);
   localparam int SW    = $clog2(HANDLES);
   localparam int WB    = (HANDLES >= 16) ? 16 : (1 << $clog2(HANDLES));
   localparam int WL    = $clog2(WB);
   localparam int ROWS  = (HANDLES + WB - 1) / WB;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RSP_W = (((2 * HW + ADDR_W) + 7) / 8) * 8;

   // memories: occupancy rows and the address store
   logic [WB-1:0]     occ_mem  [ROWS];
   logic [ADDR_W-1:0] addr_mem [HANDLES];
   logic [WB-1:0]     occ_rd_ff;
   logic [ADDR_W-1:0] addr_rd_ff;

   state_type         state_ff, state_in;
   logic [ROWS-1:0]   rv_ff;
   logic [ROWS-1:0]   full_ff;
   logic [HW-1:0]     count_ff, count_in;

   cmd_type           cmd_ff;
   logic [HW-1:0]     handle_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [RW-1:0]     row_ff;
   logic [WL-1:0]     bit_ff;
   logic              in_range_ff;
   logic              all_full_ff;

   logic [HW-1:0]     res_handle_ff;
   logic [ADDR_W-1:0] res_addr_ff;
   status_type        res_status_ff;
   logic [HW-1:0]     res_count_ff;

   logic              rsp_valid_ff;
   logic [HW-1:0]     rsp_handle_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   status_type        rsp_status_ff;
   logic [HW-1:0]     rsp_count_ff;

   logic              accept_w;
   logic              out_free_w;
   cmd_type           cmd_w;
   logic [HW-1:0]     handle_w;
   logic [ADDR_W-1:0] addr_w;
   logic              in_range_w;
   logic [SW-1:0]     slot_w;
   logic [RW-1:0]     hrow_w;
   logic [RW-1:0]     free_row_w;
   logic [RW-1:0]     rd_row_w;

   logic [WB-1:0]     word_w;
   logic [WB-1:0]     pad_w;
   logic [WB-1:0]     srch_w;
   logic [WL-1:0]     fbit_w;
   logic [WB-1:0]     fhot_w;
   logic              held_w;
   logic              occ_we;
   logic [WB-1:0]     occ_wdata;
   logic              addr_we;
   logic [SW-1:0]     alloc_slot_w;
   logic              new_full_w;
   logic              clear_all_w;
   logic [HW-1:0]     res_handle_in;
   logic [ADDR_W-1:0] res_addr_in;
   status_type        res_status_in;

   // handshake
   assign out_free_w = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_SEND) && out_free_w);
   assign accept_w   = req_tvalid && req_tready;

   // request decode
   assign cmd_w      = cmd_type'(req_tuser);
   assign handle_w   = req_tdata[HW-1:0];
   assign addr_w     = req_tdata[HW+ADDR_W-1:HW];
   assign in_range_w = (handle_w != '0) && (handle_w <= HW'(HANDLES));
   assign slot_w     = in_range_w ? SW'(handle_w - HW'(1)) : '0;
   assign hrow_w     = RW'(slot_w >> WL);

   // lowest row that still has a free handle
   always_comb begin
      free_row_w = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!full_ff[r]) begin
            free_row_w = RW'(r);
         end
      end
   end

   assign rd_row_w = (cmd_w == CMD_ALLOC) ? free_row_w : hrow_w;

   // request capture
   always_ff @(posedge clock) begin
      if (accept_w) begin
         cmd_ff      <= cmd_w;
         handle_ff   <= handle_w;
         addr_ff     <= addr_w;
         row_ff      <= rd_row_w;
         bit_ff      <= slot_w[WL-1:0];
         in_range_ff <= in_range_w;
         all_full_ff <= &full_ff;
      end
   end

   // memory reads on accept, writes in execute
   always_ff @(posedge clock) begin
      if (accept_w) begin
         occ_rd_ff  <= occ_mem[rd_row_w];
         addr_rd_ff <= addr_mem[slot_w];
      end
      if (occ_we) begin
         occ_mem[row_ff] <= occ_wdata;
      end
      if (addr_we) begin
         addr_mem[alloc_slot_w] <= addr_ff;
      end
   end

   // row contents, with handles past the end marked taken
   assign word_w = rv_ff[row_ff] ? occ_rd_ff : '0;

   always_comb begin
      for (int b = 0; b < WB; b++) begin
         pad_w[b] = ((int'(row_ff) * WB + b) >= HANDLES);
      end
   end

   assign srch_w = word_w | pad_w;

   // lowest zero bit in the row
   always_comb begin
      fbit_w = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (!srch_w[b]) begin
            fbit_w = WL'(b);
         end
      end
   end

   assign fhot_w       = WB'(1) << fbit_w;
   assign held_w       = in_range_ff && word_w[bit_ff];
   assign alloc_slot_w = SW'({row_ff, fbit_w});

   // execute: command decode and write back
   always_comb begin
      occ_we        = 1'b0;
      occ_wdata     = word_w;
      addr_we       = 1'b0;
      new_full_w    = 1'b0;
      clear_all_w   = 1'b0;
      count_in      = count_ff;
      res_handle_in = handle_ff;
      res_addr_in   = '0;
      res_status_in = ST_OK;
      if (state_ff == S_EXEC) begin
         unique case (cmd_ff)
            CMD_ALLOC: begin
               if (all_full_ff) begin
                  res_handle_in = '0;
                  res_status_in = ST_FULL;
               end else begin
                  occ_we        = 1'b1;
                  occ_wdata     = word_w | fhot_w;
                  addr_we       = 1'b1;
                  new_full_w    = &(srch_w | fhot_w);
                  count_in      = count_ff + HW'(1);
                  res_handle_in = HW'({row_ff, fbit_w}) + HW'(1);
               end
            end
            CMD_LOOKUP: begin
               if (handle_ff != '0) begin
                  if (held_w) begin
                     res_addr_in = addr_rd_ff;
                  end else begin
                     res_status_in = ST_NO_KEY;
                  end
               end
            end
            CMD_FREE: begin
               if (held_w) begin
                  occ_we    = 1'b1;
                  occ_wdata = word_w & ~(WB'(1) << bit_ff);
                  count_in  = count_ff - HW'(1);
               end else begin
                  res_status_in = ST_NO_KEY;
               end
            end
            CMD_FREE_ALL: begin
               clear_all_w = 1'b1;
               count_in    = '0;
            end
         endcase
      end
   end

   // row flags and live count
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= '0;
         full_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (clear_all_w) begin
            rv_ff   <= '0;
            full_ff <= '0;
         end else if (occ_we) begin
            rv_ff[row_ff]   <= 1'b1;
            full_ff[row_ff] <= new_full_w;
         end
      end
   end

   // result hold register
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         res_handle_ff <= res_handle_in;
         res_addr_ff   <= res_addr_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= count_in;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_w) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_free_w) begin
               state_in = accept_w ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_SEND) && out_free_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_SEND) && out_free_w) begin
         rsp_handle_ff <= res_handle_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_addr_ff, rsp_handle_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule : lowest_free_handle_table_top

`default_nettype wire

// ----- bench/lowest_free_handle_table_checker.sv -----
`timescale 1ns / 1ps

module lowest_free_handle_table_checker
   import lfht_pkg::*;
#(
   parameter int HANDLES = 256
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_tvalid,
   input  wire                                      req_tready,
   // handle_in, object_address, zero fill
   input  wire  [(($clog2(HANDLES + 1) + ADDR_W + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  wire  [1:0]                               req_tuser,
   input  wire                                      rsp_tvalid,
   input  wire                                      rsp_tready,
   // handle_out, address_out, live_count, zero fill
   input  wire  [((2 * $clog2(HANDLES + 1) + ADDR_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   input  wire  [1:0]                               rsp_tuser,
   output int                                       fail_count,
   output int                                       pending_count
);

   localparam int HW = $clog2(HANDLES + 1);

   typedef struct packed {
      logic [HW-1:0]     handle;
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic [HW-1:0]     live;
   } table_result_type;

   // shadow of the handle table
   logic              held [1:HANDLES];
   logic [ADDR_W-1:0] stored_address [1:HANDLES];
   int unsigned       live_handles;
   table_result_type  expected_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // apply one command to the shadow table and form its result
   task automatic apply_table_command(input cmd_type cmd, input logic [HW-1:0] h,
                                      input logic [ADDR_W-1:0] a,
                                      output table_result_type r);
      bit found;
      found     = 0;
      r.handle  = h;
      r.address = '0;
      r.status  = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            r.handle = '0;
            r.status = ST_FULL;
            for (int i = 1; i <= HANDLES; i++) begin
               if (!found && !held[i]) begin
                  held[i]           = 1'b1;
                  stored_address[i] = a;
                  live_handles++;
                  r.handle = HW'(i);
                  r.status = ST_OK;
                  found    = 1;
               end
            end
         end
         CMD_LOOKUP: begin
            // null handle reads as address zero with ok status
            if (h != 0) begin
               if (h > HANDLES) r.status = ST_NO_KEY;
               else if (!held[h]) r.status = ST_NO_KEY;
               else r.address = stored_address[h];
            end
         end
         CMD_FREE: begin
            if (h == 0 || h > HANDLES) r.status = ST_NO_KEY;
            else if (!held[h]) r.status = ST_NO_KEY;
            else begin
               held[h] = 1'b0;
               live_handles--;
            end
         end
         default: begin
            for (int i = 1; i <= HANDLES; i++) held[i] = 1'b0;
            live_handles = 0;
         end
      endcase
      r.live = HW'(live_handles);
   endtask

   // compare results first, then queue the prediction for the item taken this edge
   always @(posedge clock) begin
      table_result_type want;
      table_result_type got;
      if (reset) begin
         for (int i = 1; i <= HANDLES; i++) held[i] = 1'b0;
         live_handles = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.handle  = rsp_tdata[HW-1:0];
            got.address = rsp_tdata[HW +: ADDR_W];
            got.live    = rsp_tdata[HW + ADDR_W +: HW];
            got.status  = status_type'(rsp_tuser);
            if (expected_results.size() == 0) begin
               $error("result item with no expectation pending");
               fail_count = fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.handle !== want.handle) begin
                  $error("handle_out: expected %0d, actual %0d", want.handle, got.handle);
                  fail_count = fail_count + 1;
               end
               if (got.address !== want.address) begin
                  $error("address_out: expected %h, actual %h", want.address, got.address);
                  fail_count = fail_count + 1;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_count = fail_count + 1;
               end
               if (got.live !== want.live) begin
                  $error("live_count: expected %0d, actual %0d", want.live, got.live);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_table_command(cmd_type'(req_tuser), req_tdata[HW-1:0],
                                req_tdata[HW +: ADDR_W], want);
            expected_results.push_back(want);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ----- bench/lowest_free_handle_table_top_tb.sv -----
`timescale 1ns / 1ps

module lowest_free_handle_table_top_tb;
   import lfht_pkg::*;

   localparam int HANDLES = 256;
   localparam int HW      = $clog2(HANDLES + 1);
   localparam int REQ_W   = ((HW + ADDR_W + 7) / 8) * 8;
   localparam int RSP_W   = ((2 * HW + ADDR_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int held_hint   = 0;
   int stall_mode  = 0;
   int stall_timer = 0;

   always #2 clock = ~clock;

   lowest_free_handle_table_top #(.HANDLES(HANDLES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lowest_free_handle_table_checker #(.HANDLES(HANDLES)) table_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lowest_free_handle_table_top regression: fail");
         $finish;
      end
   end

   // receiver back-pressure, switching pattern every so often
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(20, 120);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 3 == 0);
      endcase
   end

   // offer one item, idling between bursts, and hold it until taken
   task automatic send_item(input cmd_type cmd, input logic [HW-1:0] h,
                            input logic [ADDR_W-1:0] a);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'({a, h});
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
      case (cmd)
         CMD_ALLOC:  if (held_hint < HANDLES) held_hint++;
         CMD_FREE:   if (held_hint > 0) held_hint--;
         CMD_FREE_ALL: held_hint = 0;
         default: ;
      endcase
   endtask

   // stop offering items until every result has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // handle mostly inside the occupied region, sometimes anywhere in 9 bits
   function automatic logic [HW-1:0] pick_handle();
      int span;
      int r;
      span = (held_hint + 2 > HANDLES) ? HANDLES : held_hint + 2;
      r    = $urandom_range(0, 99);
      if (r < 85) return HW'($urandom_range(1, span));
      if (r < 95) return HW'($urandom_range(0, HANDLES));
      return HW'($urandom_range(HANDLES + 1, (1 << HW) - 1));
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int start_count;
      int n;
      int r;
      int fills;
      cmd_type cmd;
      fills = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, address extremes, null and out-of-range handles
      send_item(CMD_LOOKUP, HW'(0), 32'h0000_0000);
      send_item(CMD_FREE, HW'(0), 32'hFFFF_FFFF);
      send_item(CMD_LOOKUP, HW'(1), 32'h0);
      send_item(CMD_FREE, HW'(HANDLES), 32'h0);
      send_item(CMD_ALLOC, '1, 32'h0000_0000);
      send_item(CMD_ALLOC, HW'(0), 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, HW'(5), 32'hA5A5_5A5A);
      send_item(CMD_LOOKUP, HW'(1), 32'hFFFF_FFFF);
      send_item(CMD_LOOKUP, HW'(2), 32'h0);
      send_item(CMD_LOOKUP, HW'(HANDLES), 32'h0);
      send_item(CMD_LOOKUP, '1, 32'h0);
      send_item(CMD_FREE, HW'(300), 32'h0);
      send_item(CMD_FREE, HW'(2), 32'h0);
      send_item(CMD_LOOKUP, HW'(2), 32'h0);
      send_item(CMD_FREE, HW'(2), 32'h0);
      // the freed hole is the lowest free handle again
      send_item(CMD_ALLOC, HW'(0), 32'h1234_5678);
      send_item(CMD_LOOKUP, HW'(2), 32'h0);
      send_item(CMD_LOOKUP, HW'(0), 32'hFFFF_FFFF);
      send_item(CMD_FREE_ALL, HW'(9'h155), 32'hDEAD_BEEF);
      send_item(CMD_LOOKUP, HW'(3), 32'h0);
      send_item(CMD_FREE_ALL, HW'(0), 32'h0);
      send_item(CMD_ALLOC, HW'(HANDLES), 32'h8000_0001);
      send_item(CMD_LOOKUP, HW'(1), 32'h0);
      wait_drained();

      // random episodes: table fills to full, and mixed traffic
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if (fills == 0 || (fills < 3 && $urandom_range(0, 9) == 0)) begin
            fills++;
            send_item(CMD_FREE_ALL, pick_handle(), pick_address());
            repeat (HANDLES + 3) send_item(CMD_ALLOC, pick_handle(), pick_address());
            repeat (20) send_item(CMD_LOOKUP, HW'($urandom_range(1, HANDLES)), pick_address());
            repeat (12) send_item(CMD_FREE, HW'($urandom_range(1, HANDLES)), pick_address());
            repeat (6) send_item(CMD_ALLOC, pick_handle(), pick_address());
            held_hint = HANDLES;
         end else begin
            n = $urandom_range(30, 60);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 35) cmd = CMD_ALLOC;
               else if (r < 70) cmd = CMD_LOOKUP;
               else if (r < 98) cmd = CMD_FREE;
               else cmd = CMD_FREE_ALL;
               send_item(cmd, pick_handle(), pick_address());
            end
         end
         // occasional full drain between episodes, always after the first fill
         if (fills == 1 || $urandom_range(0, 3) == 0) wait_drained();
      end

      // end of stimulus: wait for the last results, then settle
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("lowest_free_handle_table_top regression: pass");
      end else begin
         $display("lowest_free_handle_table_top regression: fail");
      end
      $finish;
   end

endmodule
